// ===== hdl/gcbd_pkg.sv =====
// Package: class codes, cluster state codes and shared types for the boundary detector.
`timescale 1ns / 1ps

package gcbd_pkg;

   typedef logic [4:0] class_type;
   typedef logic [3:0] state_type;

   typedef struct packed {
      state_type state_out;
      logic      boundary;
   } step_result_type;

   localparam class_type CLASS_OTHER         = 5'd0;
   localparam class_type CLASS_CR            = 5'd1;
   localparam class_type CLASS_LF            = 5'd2;
   localparam class_type CLASS_CONTROL       = 5'd3;
   localparam class_type CLASS_EXTEND        = 5'd4;
   localparam class_type CLASS_INCB_EXTEND   = 5'd5;
   localparam class_type CLASS_INCB_LINKER   = 5'd6;
   localparam class_type CLASS_ZWJ           = 5'd7;
   localparam class_type CLASS_SPACINGMARK   = 5'd8;
   localparam class_type CLASS_PREPEND       = 5'd9;
   localparam class_type CLASS_L             = 5'd10;
   localparam class_type CLASS_V             = 5'd11;
   localparam class_type CLASS_T             = 5'd12;
   localparam class_type CLASS_LV            = 5'd13;
   localparam class_type CLASS_LVT           = 5'd14;
   localparam class_type CLASS_RI            = 5'd15;
   localparam class_type CLASS_PICTO         = 5'd16;
   localparam class_type CLASS_CONSONANT     = 5'd17;

   localparam state_type ST_GROUND           = 4'd0;
   localparam state_type ST_AFTER_CR         = 4'd1;
   localparam state_type ST_PRECORE          = 4'd2;
   localparam state_type ST_POSTCORE         = 4'd3;
   localparam state_type ST_RI               = 4'd4;
   localparam state_type ST_HANGUL_L         = 4'd5;
   localparam state_type ST_HANGUL_T         = 4'd6;
   localparam state_type ST_HANGUL_V         = 4'd7;
   localparam state_type ST_PICTO_ZWJ        = 4'd8;
   localparam state_type ST_PICTO_NEXT       = 4'd9;
   localparam state_type ST_CONJ_LINKER      = 4'd10;
   localparam state_type ST_CONJ_CONSONANT   = 4'd11;
   // cluster closes with this code point, then ground
   localparam state_type ST_CLOSE            = 4'd12;

endpackage

// ===== hdl/gcbd_step.sv =====
// Combinational cluster recognizer step: next state and boundary flag for one class.
`timescale 1ns / 1ps

module gcbd_step
   import gcbd_pkg::*;
(
   input  state_type       state_in,
   input  class_type       class_in,
   output step_result_type result
);

   function automatic state_type nx_postcore(input class_type c);
      state_type r;
      case (c) inside
         CLASS_EXTEND, CLASS_INCB_EXTEND, CLASS_INCB_LINKER,
         CLASS_ZWJ, CLASS_SPACINGMARK: r = ST_POSTCORE;
         default: r = ST_GROUND;
      endcase
      return r;
   endfunction

   function automatic state_type nx_precore(input class_type c);
      state_type r;
      case (c) inside
         CLASS_PREPEND: r = ST_PRECORE;
         CLASS_L: r = ST_HANGUL_L;
         CLASS_V, CLASS_LV: r = ST_HANGUL_V;
         CLASS_LVT, CLASS_T: r = ST_HANGUL_T;
         CLASS_RI: r = ST_RI;
         CLASS_PICTO: r = ST_PICTO_ZWJ;
         CLASS_CONSONANT: r = ST_CONJ_LINKER;
         CLASS_CONTROL, CLASS_LF, CLASS_CR: r = ST_GROUND;
         default: r = ST_POSTCORE;
      endcase
      return r;
   endfunction

   function automatic state_type nx_ground(input class_type c);
      state_type r;
      case (c) inside
         CLASS_CONTROL, CLASS_LF: r = ST_CLOSE;
         CLASS_CR: r = ST_AFTER_CR;
         default: r = nx_precore(c);
      endcase
      return r;
   endfunction

   function automatic state_type nx_state(input state_type s, input class_type c);
      state_type r;
      unique case (s)
         ST_AFTER_CR: begin
            r = (c == CLASS_LF) ? ST_CLOSE : ST_GROUND;
         end
         ST_PRECORE: r = nx_precore(c);
         ST_POSTCORE: r = nx_postcore(c);
         ST_RI: begin
            r = (c == CLASS_RI) ? ST_POSTCORE : nx_postcore(c);
         end
         ST_HANGUL_L: begin
            if (c == CLASS_L) r = ST_HANGUL_L;
            else if (c == CLASS_V || c == CLASS_LV) r = ST_HANGUL_V;
            else if (c == CLASS_LVT) r = ST_HANGUL_T;
            else r = nx_postcore(c);
         end
         ST_HANGUL_T: begin
            r = (c == CLASS_T) ? ST_HANGUL_T : nx_postcore(c);
         end
         ST_HANGUL_V: begin
            if (c == CLASS_V) r = ST_HANGUL_V;
            else if (c == CLASS_T) r = ST_HANGUL_T;
            else r = nx_postcore(c);
         end
         ST_PICTO_ZWJ: begin
            if (c == CLASS_EXTEND || c == CLASS_INCB_EXTEND || c == CLASS_INCB_LINKER)
               r = ST_PICTO_ZWJ;
            else if (c == CLASS_ZWJ) r = ST_PICTO_NEXT;
            else r = nx_postcore(c);
         end
         ST_PICTO_NEXT: begin
            r = (c == CLASS_PICTO) ? ST_PICTO_ZWJ : nx_postcore(c);
         end
         ST_CONJ_LINKER: begin
            if (c == CLASS_INCB_LINKER) r = ST_CONJ_CONSONANT;
            else if (c == CLASS_INCB_EXTEND || c == CLASS_ZWJ) r = ST_CONJ_LINKER;
            else r = nx_postcore(c);
         end
         ST_CONJ_CONSONANT: begin
            if (c == CLASS_CONSONANT) r = ST_CONJ_LINKER;
            else if (c == CLASS_INCB_LINKER || c == CLASS_INCB_EXTEND || c == CLASS_ZWJ)
               r = ST_CONJ_CONSONANT;
            else r = nx_postcore(c);
         end
         default: r = nx_ground(c);
      endcase
      return r;
   endfunction

   class_type cls;
   state_type st;
   state_type nx;
   state_type nx_retry;
   logic      bnd;

   always_comb begin
      // out-of-range classes act as other; unreachable states act as ground
      cls = (class_in > CLASS_CONSONANT) ? CLASS_OTHER : class_in;
      st  = (state_in >= ST_CLOSE) ? ST_GROUND : state_in;
      nx  = nx_state(st, cls);
      bnd = (st == ST_GROUND);
      nx_retry = nx_ground(cls);
      if (nx == ST_GROUND) begin
         nx  = nx_retry;
         bnd = 1'b1;
      end
      if (nx == ST_CLOSE) begin
         nx = ST_GROUND;
      end
      result.state_out = nx;
      result.boundary  = bnd;
   end

endmodule

// ===== hdl/grapheme_cluster_boundary_detector_unit.sv =====
// Top level: grapheme cluster boundary detector with input and result registers.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_break_class (5b)
//   rsp      out        rsp_valid / rsp_ready  rsp_boundary_before (1b)
//
// One class per cycle unless rsp stalls; rsp_valid flags the result register.
// The input register feeds the recognizer step, whose result lands in the result
// register while the cluster state updates in the same cycle.
// Synchronous reset puts the cluster state at ground and empties both registers.
// A stalled rsp holds the result register; the input register still takes one item.
`timescale 1ns / 1ps

module grapheme_cluster_boundary_detector_unit
   import gcbd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  class_type req_break_class,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output logic      rsp_boundary_before
);

   logic            in_valid_ff;
   logic            in_valid_in;
   class_type       in_class_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   logic            out_bnd_ff;
   state_type       cluster_state_ff;
   logic            advance;
   step_result_type step;

   gcbd_step u_step (
      .state_in (cluster_state_ff),
      .class_in (in_class_ff),
      .result   (step)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      if (advance) begin
         out_valid_in = 1'b1;
         in_valid_in  = 1'b0;
      end
      if (req_valid && req_ready) in_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         cluster_state_ff <= ST_GROUND;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) cluster_state_ff <= step.state_out;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_class_ff <= req_break_class;
      if (advance) out_bnd_ff <= step.boundary;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_boundary_before = out_bnd_ff;

endmodule
